/* src/dqr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_pkg
// Shared types and codes for the deque with remove-by-value.
// ----------------------------------------------------------------------------
package dqr_pkg;

    localparam logic [2:0] OP_PUSH_L = 3'd0;
    localparam logic [2:0] OP_PUSH_R = 3'd1;
    localparam logic [2:0] OP_POP_L  = 3'd2;
    localparam logic [2:0] OP_POP_R  = 3'd3;
    localparam logic [2:0] OP_SEARCH = 3'd4;
    localparam logic [2:0] OP_REMOVE = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] operand_value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] result_value;
        logic [4:0]         entry_count;
    } t_rsp;

    typedef struct packed {
        logic shift_r;    // take left neighbor
        logic shift_l;    // take right neighbor
        logic remove;     // take right neighbor at and after first hit
        logic load_tail;  // load key at the free slot
    } t_cell_ctrl;

endpackage

/* src/dqr_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_cell
// One storage cell of the deque: holds an entry, compares it to the key and
// passes hit and tail-read chains on to its right neighbor.
// ----------------------------------------------------------------------------
module dqr_cell (
    input  logic                i_clk,
    input  dqr_pkg::t_cell_ctrl i_ctrl,
    input  logic [31:0]         i_left,
    input  logic [31:0]         i_right,
    input  logic [31:0]         i_key,
    input  logic                i_occ,
    input  logic                i_at_count,
    input  logic                i_is_last,
    input  logic                i_hit_before,
    input  logic [31:0]         i_tail_before,
    output logic [31:0]         o_data,
    output logic                o_hit_through,
    output logic [31:0]         o_tail_through
);
    import dqr_pkg::*;

    logic [31:0] r_data;
    logic [31:0] n_data;
    logic        w_hit;

    assign w_hit          = i_occ && (r_data == i_key);
    assign o_hit_through  = i_hit_before | w_hit;
    assign o_tail_through = i_tail_before | (r_data & {32{i_is_last}});
    assign o_data         = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift_r) begin
            n_data = i_left;
        end else if (i_ctrl.shift_l || (i_ctrl.remove && o_hit_through)) begin
            n_data = i_right;
        end else if (i_ctrl.load_tail && i_at_count) begin
            n_data = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* src/deque_with_remove_by_value.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_remove_by_value
// Bounded double-ended queue of signed 32-bit values built as a row of cells,
// with push/pop at both ends, search, and remove of the leftmost match.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// request   in         start & !busy         i_req (operation, operand_value)
// result    out        o_strobe, one cycle   o_rsp (status, result_value,
//                                                   entry_count)
//
// Each request passes through an execute state in which all cells compare
// and shift together, then the result strobe. busy is high only during the
// execute state, so a new request is taken in the strobe cycle.
// Synchronous active-low reset empties the deque; entry contents are not
// reset. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module deque_with_remove_by_value #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  dqr_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output dqr_pkg::t_rsp o_rsp
);
    import dqr_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state        r_state;
    t_req          r_req;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_strobe;
    t_rsp          r_rsp;
    t_rsp          n_rsp;

    logic [31:0]   w_key;
    logic          w_full;
    logic          w_empty;
    logic          w_found;
    logic [31:0]   w_tail;
    t_cell_ctrl    w_ctrl;
    logic [CW+4:0] w_count_ext;

    logic [31:0]   w_data  [DEPTH];
    logic [DEPTH:0] w_hit_chain;
    logic [31:0]   w_tail_chain [DEPTH+1];

    assign w_key   = 32'(r_req.operand_value);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_found = w_hit_chain[DEPTH];
    assign w_tail  = w_tail_chain[DEPTH];

    assign w_hit_chain[0]  = 1'b0;
    assign w_tail_chain[0] = '0;

    always_comb begin
        w_ctrl           = '0;
        if (r_state == S_EXEC) begin
            w_ctrl.shift_r   = (r_req.operation == OP_PUSH_L) && !w_full;
            w_ctrl.load_tail = (r_req.operation == OP_PUSH_R) && !w_full;
            w_ctrl.shift_l   = (r_req.operation == OP_POP_L) && !w_empty;
            w_ctrl.remove    = (r_req.operation == OP_REMOVE) && w_found;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            localparam logic [CW-1:0] IDX  = CW'(gi);
            localparam logic [CW-1:0] IDX1 = CW'(gi + 1);
            logic [31:0] w_left;
            logic [31:0] w_right;

            if (gi == 0) begin : g_first
                assign w_left = w_key;
            end else begin : g_mid
                assign w_left = w_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_data[gi+1];
            end

            dqr_cell u_cell (
                .i_clk          (i_clk),
                .i_ctrl         (w_ctrl),
                .i_left         (w_left),
                .i_right        (w_right),
                .i_key          (w_key),
                .i_occ          (r_count > IDX),
                .i_at_count     (r_count == IDX),
                .i_is_last      (r_count == IDX1),
                .i_hit_before   (w_hit_chain[gi]),
                .i_tail_before  (w_tail_chain[gi]),
                .o_data         (w_data[gi]),
                .o_hit_through  (w_hit_chain[gi+1]),
                .o_tail_through (w_tail_chain[gi+1])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        n_rsp   = '0;
        case (r_req.operation)
            OP_PUSH_L, OP_PUSH_R: begin
                if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_L: begin
                if (w_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.result_value = w_data[0];
                    n_count            = r_count - 1'b1;
                end
            end
            OP_POP_R: begin
                if (w_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.result_value = w_tail;
                    n_count            = r_count - 1'b1;
                end
            end
            OP_SEARCH: begin
                if (w_found) begin
                    n_rsp.result_value = w_key;
                end else begin
                    n_rsp.status = ST_NOT_FOUND;
                end
            end
            OP_REMOVE: begin
                if (w_found) begin
                    n_rsp.result_value = w_key;
                    n_count            = r_count - 1'b1;
                end else begin
                    n_rsp.status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
        w_count_ext       = {5'b0, n_count};
        n_rsp.entry_count = w_count_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_count  <= n_count;
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_req <= i_req;
        end
        if (r_state == S_EXEC) begin
            r_rsp <= n_rsp;
        end
    end

    assign busy     = (r_state == S_EXEC);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

/* src/dqr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_checker
// Port-level checks on request/result timing and result encoding.
// ----------------------------------------------------------------------------
module dqr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input dqr_pkg::t_req i_req,
    input logic          o_strobe,
    input dqr_pkg::t_rsp o_rsp
);
    import dqr_pkg::*;

    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("request without result two cycles later");

    a_rsp_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) && !busy))
        else $error("result not preceded by execute cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status != ST_OK) |-> (o_rsp.result_value == 0))
        else $error("nonzero value on failed request");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status == ST_EMPTY) |-> (o_rsp.entry_count == 0))
        else $error("empty status with nonzero count");

    a_req_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule

bind deque_with_remove_by_value dqr_checker u_dqr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);

/* tb/sv/dqr_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_result_checker
// Watches the request and result channels of the deque. It keeps its own copy
// of the deque contents, predicts the result of every accepted request, and
// compares each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dqr_result_checker
    import dqr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_busy,
    input  t_req  i_req,
    input  logic  i_strobe,
    input  t_rsp  i_rsp,
    output int    o_fail_count,
    output int    o_pending
);

    logic signed [31:0] deque_contents[$];
    t_rsp               pending_results[$];
    int                 fails = 0;

    function automatic t_rsp predict_deque_op(t_req req);
        t_rsp rsp;
        int   hit;
        rsp = '0;
        hit = -1;
        if (req.operation == OP_SEARCH || req.operation == OP_REMOVE) begin
            foreach (deque_contents[i]) begin
                if (hit < 0 && deque_contents[i] == req.operand_value) hit = i;
            end
        end
        case (req.operation)
            OP_PUSH_L, OP_PUSH_R: begin
                if (deque_contents.size() >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else if (req.operation == OP_PUSH_L) begin
                    deque_contents.push_front(req.operand_value);
                end else begin
                    deque_contents.push_back(req.operand_value);
                end
            end
            OP_POP_L, OP_POP_R: begin
                if (deque_contents.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (req.operation == OP_POP_L) begin
                    rsp.result_value = deque_contents.pop_front();
                end else begin
                    rsp.result_value = deque_contents.pop_back();
                end
            end
            OP_SEARCH, OP_REMOVE: begin
                if (hit < 0) begin
                    rsp.status = ST_NOT_FOUND;
                end else begin
                    rsp.result_value = deque_contents[hit];
                    if (req.operation == OP_REMOVE) deque_contents.delete(hit);
                end
            end
            default: ;
        endcase
        rsp.entry_count = 5'(deque_contents.size());
        return rsp;
    endfunction

    task automatic note_failure(string msg);
        fails++;
        if (fails <= 10) $display("%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            deque_contents.delete();
            pending_results.delete();
        end else begin
            if (i_strobe) begin
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: st=%0d val=%0d cnt=%0d",
                        i_rsp.status, i_rsp.result_value, i_rsp.entry_count));
                end else begin
                    exp_rsp = pending_results.pop_front();
                    if (exp_rsp.status !== i_rsp.status ||
                        exp_rsp.result_value !== i_rsp.result_value ||
                        exp_rsp.entry_count !== i_rsp.entry_count) begin
                        note_failure($sformatf(
                            {"mismatch: expected st=%0d val=%0d cnt=%0d, ",
                             "got st=%0d val=%0d cnt=%0d"},
                            exp_rsp.status, exp_rsp.result_value, exp_rsp.entry_count,
                            i_rsp.status, i_rsp.result_value, i_rsp.entry_count));
                    end
                end
            end
            if (i_start && !i_busy) pending_results.push_back(predict_deque_op(i_req));
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/sv/deque_with_remove_by_value_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_remove_by_value_test
// Drives directed and random request sequences into the deque in bursts with
// random gaps; a checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module deque_with_remove_by_value_test;
    import dqr_pkg::*;

    localparam logic [2:0]         OP_SPARE_A = 3'd6;
    localparam logic [2:0]         OP_SPARE_B = 3'd7;
    localparam logic signed [31:0] VAL_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN    = 32'sh8000_0000;
    localparam int                 NUM_RANDOM = 1800;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_LOOKUP} t_mix;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;
    int   fail_count;
    int   pending;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    deque_with_remove_by_value dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    dqr_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic issue(input logic [2:0] op, input logic signed [31:0] val);
        start               <= 1'b1;
        i_req.operation     <= op;
        i_req.operand_value <= val;
        do @(posedge i_clk); while (busy);
    endtask

    // start low, junk on the payload
    task automatic idle(input int cycles);
        if (cycles > 0) begin
            start               <= 1'b0;
            i_req.operation     <= 3'($urandom_range(0, 7));
            i_req.operand_value <= $urandom;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // small pool so lookups hit often, plus extremes and full-range values
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return 32'(int'($urandom_range(0, 9)) - 4);
        endcase
    endfunction

    function automatic logic [2:0] pick_op(t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return r[0] ? OP_SPARE_A : OP_SPARE_B;
        case (mix)
            MIX_FILL:   if (r < 80) return r[0] ? OP_PUSH_L : OP_PUSH_R;
            MIX_DRAIN:  if (r < 80) return r[0] ? OP_POP_L : OP_POP_R;
            MIX_LOOKUP: if (r < 60) return r[0] ? OP_SEARCH : OP_REMOVE;
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: return OP_PUSH_L;
            1: return OP_PUSH_R;
            2: return OP_POP_L;
            3: return OP_POP_R;
            4: return OP_SEARCH;
            default: return OP_REMOVE;
        endcase
    endfunction

    initial begin
        #2_000_000;
        $display("** deque_with_remove_by_value: FAILED **");
        $finish;
    end

    initial begin
        t_mix mix;
        int   mix_left;
        int   burst_left;
        int   waited;
        mix        = MIX_FILL;
        mix_left   = 0;
        burst_left = 0;
        waited     = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(OP_POP_L, 32'sd0);
        issue(OP_POP_R, 32'sd0);
        issue(OP_SEARCH, 32'sd5);
        issue(OP_REMOVE, 32'sd5);
        issue(OP_SPARE_A, 32'sd0);
        issue(OP_SPARE_B, -32'sd1);
        issue(OP_PUSH_L, VAL_MAX);
        issue(OP_PUSH_R, VAL_MIN);
        issue(OP_PUSH_L, 32'sd0);
        issue(OP_PUSH_R, -32'sd1);
        issue(OP_PUSH_R, 32'sd7);
        issue(OP_PUSH_L, 32'sd7);
        idle(2);
        issue(OP_SEARCH, VAL_MIN);
        issue(OP_SEARCH, 32'sd3);
        issue(OP_REMOVE, 32'sd7);
        issue(OP_SEARCH, 32'sd7);
        issue(OP_REMOVE, VAL_MAX);
        idle(1);
        issue(OP_POP_L, 32'sd0);
        issue(OP_POP_R, 32'sd0);
        issue(OP_POP_R, 32'sd0);
        issue(OP_POP_L, 32'sd0);
        issue(OP_POP_R, 32'sd0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (mix_left == 0) begin
                mix      = t_mix'($urandom_range(0, 3));
                mix_left = $urandom_range(20, 60);
            end
            mix_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5));
            end
            burst_left--;
            issue(pick_op(mix), pick_value());
        end
        start <= 1'b0;

        while (pending != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (5) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("** deque_with_remove_by_value: PASSED **");
        end else begin
            $display("** deque_with_remove_by_value: FAILED **");
        end
        $finish;
    end

endmodule
